// ===== hw/rtl/isc64_pkg.sv =====
// ----------------------------------------------------------------------------
// ISAAC64 generator package
// Sizes, command codes and the mixing functions shared by the generator.
// ----------------------------------------------------------------------------
package isc64_pkg;

  localparam int unsigned SizeLog2 = 8;
  localparam int unsigned Size     = 1 << SizeLog2;
  localparam int unsigned IdxW     = SizeLog2;
  localparam int unsigned PosW     = SizeLog2 + 1;
  localparam int unsigned GrpW     = SizeLog2 - 3;

  localparam logic [63:0] Golden = 64'h9e3779b97f4a7c13;

  localparam logic [1:0] CmdLoad = 2'd0;
  localparam logic [1:0] CmdInit = 2'd1;
  localparam logic [1:0] CmdDraw = 2'd2;

  typedef logic [7:0][63:0] vec_t;

  // One line of the golden-ratio scrambler; eight lines make one full round.
  function automatic vec_t scramble_row(vec_t v, logic [2:0] row);
    vec_t        r;
    logic [2:0]  p4;
    logic [2:0]  p5;
    logic [2:0]  p7;
    logic [63:0] s;
    r  = v;
    p4 = row + 3'd4;
    p5 = row + 3'd5;
    p7 = row + 3'd7;
    r[row] = r[row] - r[p4];
    case (row)
      3'd0:    s = r[p7] >> 9;
      3'd1:    s = r[p7] << 9;
      3'd2:    s = r[p7] >> 23;
      3'd3:    s = r[p7] << 15;
      3'd4:    s = r[p7] >> 14;
      3'd5:    s = r[p7] << 20;
      3'd6:    s = r[p7] >> 17;
      default: s = r[p7] << 14;
    endcase
    r[p5] = r[p5] ^ s;
    r[p7] = r[p7] + r[row];
    return r;
  endfunction

  function automatic logic [63:0] acc_mix(logic [63:0] a, logic [1:0] phase);
    logic [63:0] m;
    case (phase)
      2'd0:    m = ~(a ^ (a << 21));
      2'd1:    m = a ^ (a >> 5);
      2'd2:    m = a ^ (a << 12);
      default: m = a ^ (a >> 33);
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/isc64_if.sv =====
// ----------------------------------------------------------------------------
// ISAAC64 generator channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface isc64_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  seed_index;
  logic [63:0] seed_word;
  modport source (output valid, cmd, seed_index, seed_word, input ready);
  modport sink (input valid, cmd, seed_index, seed_word, output ready);
endinterface

interface isc64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_value;
  logic        value_valid;
  modport source (output valid, random_value, value_valid, input ready);
  modport sink (input valid, random_value, value_valid, output ready);
endinterface

// ===== hw/rtl/isc64_ram.sv =====
// ----------------------------------------------------------------------------
// ISAAC64 generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module isc64_ram #(
  parameter int unsigned AddrW = 8,
  parameter int unsigned DataW = 64
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);
  logic [DataW-1:0] mem [1 << AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== hw/rtl/isaac64_generator.sv =====
// ----------------------------------------------------------------------------
// ISAAC64 generator
// Seed loading, initialization and 64-bit number draws over two memories.
// ----------------------------------------------------------------------------
// One command item is taken at a time. A load writes its seed word into the
// result buffer; a load or unused command returns an item with value_valid
// low. A draw from a filled buffer goes through one memory read of the result
// buffer and the output register. When the buffer is used up, the draw first
// regenerates a block: 256 steps through states G0 to G5, bound by the four
// reads of the main memory's single read port. An init runs 32 scramble steps,
// two seed passes of 32 groups and one block. After reset a clearing pass
// writes zero to every entry of both memories, and no item is taken until it
// ends, so a draw before any init runs on all-zero state.
module isaac64_generator (
  input logic        clk_i,
  input logic        rst_ni,
  isc64_in_if.sink   in_i,
  isc64_out_if.source out_o
);
  import isc64_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INITSC = 4'd1;
  localparam logic [3:0] S_SPRD   = 4'd2;
  localparam logic [3:0] S_SPSC   = 4'd3;
  localparam logic [3:0] S_SPWR   = 4'd4;
  localparam logic [3:0] S_GSTART = 4'd5;
  localparam logic [3:0] S_G0     = 4'd6;
  localparam logic [3:0] S_G1     = 4'd7;
  localparam logic [3:0] S_G2     = 4'd8;
  localparam logic [3:0] S_G3     = 4'd9;
  localparam logic [3:0] S_G4     = 4'd10;
  localparam logic [3:0] S_G5     = 4'd11;
  localparam logic [3:0] S_DRRD   = 4'd12;
  localparam logic [3:0] S_DROUT  = 4'd13;
  localparam logic [3:0] S_CLEAR  = 4'd14;

  logic [3:0]      state_q, state_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [GrpW-1:0] grp_q, grp_d;
  logic            pass_q, pass_d;
  logic            draw_q, draw_d;
  logic [IdxW-1:0] i_q, i_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [63:0]     a_q, a_d;
  logic [63:0]     b_q, b_d;
  logic [63:0]     bc_q, bc_d;
  logic [63:0]     x_q, x_d;
  logic [63:0]     y_q, y_d;
  vec_t            v_q, v_d;
  logic            ov_q, ov_d;
  logic [63:0]     rv_q, rv_d;
  logic            vv_q, vv_d;

  logic            mm_we, rb_we;
  logic [IdxW-1:0] mm_waddr, mm_raddr, rb_waddr, rb_raddr;
  logic [63:0]     mm_wdata, mm_rdata, rb_wdata, rb_rdata;
  logic [63:0]     y_sum;
  logic [2:0]      vi;
  logic            accept;

  isc64_ram #(.AddrW(IdxW), .DataW(64)) u_main (
    .clk_i, .we_i(mm_we), .waddr_i(mm_waddr), .wdata_i(mm_wdata),
    .raddr_i(mm_raddr), .rdata_o(mm_rdata)
  );

  isc64_ram #(.AddrW(IdxW), .DataW(64)) u_result (
    .clk_i, .we_i(rb_we), .waddr_i(rb_waddr), .wdata_i(rb_wdata),
    .raddr_i(rb_raddr), .rdata_o(rb_rdata)
  );

  assign in_i.ready         = (state_q == S_IDLE) && !ov_q;
  assign accept             = in_i.valid && in_i.ready;
  assign out_o.valid        = ov_q;
  assign out_o.random_value = rv_q;
  assign out_o.value_valid  = vv_q;

  assign y_sum = mm_rdata + a_q + b_q;
  assign vi    = cnt_q[2:0] - 3'd1;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    grp_d   = grp_q;
    pass_d  = pass_q;
    draw_d  = draw_q;
    i_d     = i_q;
    pos_d   = pos_q;
    a_d     = a_q;
    b_d     = b_q;
    bc_d    = bc_q;
    x_d     = x_q;
    y_d     = y_q;
    v_d     = v_q;
    ov_d    = ov_q;
    rv_d    = rv_q;
    vv_d    = vv_q;
    mm_we    = 1'b0;
    mm_waddr = i_q;
    mm_wdata = y_sum;
    mm_raddr = i_q;
    rb_we    = 1'b0;
    rb_waddr = i_q;
    rb_wdata = mm_rdata + x_q;
    rb_raddr = pos_q[IdxW-1:0];

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        mm_we    = 1'b1;
        mm_wdata = '0;
        rb_we    = 1'b1;
        rb_wdata = '0;
        i_d      = i_q + IdxW'(1);
        if (i_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_i.cmd)
            CmdLoad: begin
              rb_we    = 1'b1;
              rb_waddr = in_i.seed_index[IdxW-1:0];
              rb_wdata = in_i.seed_word;
              ov_d = 1'b1;
              rv_d = '0;
              vv_d = 1'b0;
            end
            CmdInit: begin
              a_d     = '0;
              b_d     = '0;
              bc_d    = '0;
              v_d     = {8{Golden}};
              cnt_d   = '0;
              draw_d  = 1'b0;
              state_d = S_INITSC;
            end
            CmdDraw: begin
              draw_d = 1'b1;
              if (pos_q == '0) begin
                state_d = S_GSTART;
              end else begin
                pos_d   = pos_q - PosW'(1);
                state_d = S_DRRD;
              end
            end
            default: begin
              ov_d = 1'b1;
              rv_d = '0;
              vv_d = 1'b0;
            end
          endcase
        end
      end
      S_INITSC: begin
        v_d   = scramble_row(v_q, cnt_q[2:0]);
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          cnt_d   = '0;
          grp_d   = '0;
          pass_d  = 1'b0;
          state_d = S_SPRD;
        end
      end
      // Reads go out for words 0..7 of the group; each word is added the
      // cycle after its address.
      S_SPRD: begin
        mm_raddr = {grp_q, cnt_q[2:0]};
        rb_raddr = {grp_q, cnt_q[2:0]};
        if (cnt_q != '0) begin
          v_d[vi] = v_q[vi] + (pass_q ? mm_rdata : rb_rdata);
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd8) begin
          cnt_d   = '0;
          state_d = S_SPSC;
        end
      end
      S_SPSC: begin
        v_d   = scramble_row(v_q, cnt_q[2:0]);
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd7) begin
          cnt_d   = '0;
          state_d = S_SPWR;
        end
      end
      S_SPWR: begin
        mm_we    = 1'b1;
        mm_waddr = {grp_q, cnt_q[2:0]};
        mm_wdata = v_q[cnt_q[2:0]];
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == 5'd7) begin
          cnt_d   = '0;
          grp_d   = grp_q + GrpW'(1);
          state_d = S_SPRD;
          if (grp_q == '1) begin
            if (pass_q) begin
              state_d = S_GSTART;
            end else begin
              pass_d = 1'b1;
            end
          end
        end
      end
      S_GSTART: begin
        bc_d    = bc_q + 64'd1;
        b_d     = b_q + bc_q + 64'd1;
        i_d     = '0;
        state_d = S_G0;
      end
      S_G0: begin
        mm_raddr = i_q;
        state_d  = S_G1;
      end
      S_G1: begin
        x_d      = mm_rdata;
        mm_raddr = i_q + IdxW'(Size / 2);
        state_d  = S_G2;
      end
      S_G2: begin
        a_d      = acc_mix(a_q, i_q[1:0]) + mm_rdata;
        mm_raddr = x_q[3 +: IdxW];
        state_d  = S_G3;
      end
      // The write lands before the next read is issued, so a later read of
      // the same entry sees the new word.
      S_G3: begin
        mm_we   = 1'b1;
        y_d     = y_sum;
        state_d = S_G4;
      end
      S_G4: begin
        mm_raddr = y_q[3 + IdxW +: IdxW];
        state_d  = S_G5;
      end
      S_G5: begin
        rb_we   = 1'b1;
        b_d     = mm_rdata + x_q;
        i_d     = i_q + IdxW'(1);
        state_d = S_G0;
        if (i_q == '1) begin
          if (draw_q) begin
            pos_d   = PosW'(Size - 1);
            state_d = S_DRRD;
          end else begin
            pos_d   = PosW'(Size);
            ov_d    = 1'b1;
            rv_d    = '0;
            vv_d    = 1'b0;
            state_d = S_IDLE;
          end
        end
      end
      S_DRRD: begin
        state_d = S_DROUT;
      end
      S_DROUT: begin
        ov_d    = 1'b1;
        rv_d    = rb_rdata;
        vv_d    = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      grp_q   <= '0;
      pass_q  <= 1'b0;
      draw_q  <= 1'b0;
      i_q     <= '0;
      pos_q   <= '0;
      a_q     <= '0;
      b_q     <= '0;
      bc_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      grp_q   <= grp_d;
      pass_q  <= pass_d;
      draw_q  <= draw_d;
      i_q     <= i_d;
      pos_q   <= pos_d;
      a_q     <= a_d;
      b_q     <= b_d;
      bc_q    <= bc_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    v_q  <= v_d;
    rv_q <= rv_d;
    vv_q <= vv_d;
  end

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(Size))
    else $error("read position beyond buffer size");

  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !ov_q)
    else $error("result pending while a command is in progress");

  a_draw_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DROUT) |=> (ov_q && vv_q && state_q == S_IDLE))
    else $error("draw did not produce a valid number");
endmodule
